### rtl/core/bdpc_pkg.sv
// Shared types and constants for the button debounce and press classifier.
// No dependencies; used by every module in rtl/core.
package bdpc_pkg;

    localparam int DBT_W = 8;     // debounce threshold width
    localparam int LPT_W = 16;    // long-press threshold width
    localparam int PIN_W = 8;     // pins carried by a tick beat
    localparam int IDX_W = 3;     // button index width
    localparam int CNT_W = 8;     // stable counter width
    localparam int HIST_W = 3;    // sample history length
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_LONG  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL    = 2'd2;

    localparam logic [DBT_W-1:0] DBT_RESET = 8'd2;
    localparam logic [LPT_W-1:0] LPT_RESET = 16'd100;
    localparam logic             LEVEL_RESET = 1'b0;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PIN_W-1:0] pin_levels;
        logic [IDX_W-1:0] button_index;
    } in_t;

    typedef struct packed {
        logic             event_taken;
        logic [PIN_W-1:0] debounced_pressed;
    } out_t;

    typedef struct packed {
        logic [DBT_W-1:0] debounce_threshold;
        logic [LPT_W-1:0] long_press_threshold;
        logic             pressed_level;
    } cfg_t;

    // per-lane command for one accepted beat
    typedef struct packed {
        logic tick;
        logic pressed;
        logic clr_short;
        logic clr_long;
    } lane_ctl_t;

    typedef struct packed {
        logic latched_next;
        logic short_flag;
        logic long_flag;
    } lane_stat_t;

endpackage

### rtl/core/bdpc_lane.sv
// One button lane: sample history, stable counter, latch, hold counter and flags.
// Depends on bdpc_pkg.
module bdpc_lane #(
    parameter int HOLD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bdpc_pkg::cfg_t         cfg,
    input  bdpc_pkg::lane_ctl_t    ctl,
    output bdpc_pkg::lane_stat_t   stat
);

    localparam int CMP_W = (HOLD_BITS > bdpc_pkg::LPT_W) ? HOLD_BITS : bdpc_pkg::LPT_W;

    logic [bdpc_pkg::HIST_W-1:0] hist_reg, hist_next;
    logic [bdpc_pkg::CNT_W-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic                        latched_reg, latched_next;
    logic [HOLD_BITS-1:0]        hold_reg, hold_next, hold_base;
    logic                        fired_reg, fired_next, fired_base;
    logic                        short_reg, short_next;
    logic                        long_reg, long_next;
    logic                        stable, oldest, latch_evt;

    always_comb begin
        hist_next    = {hist_reg[bdpc_pkg::HIST_W-2:0], ctl.pressed};
        stable       = (hist_next == '0) || (hist_next == '1);
        oldest       = hist_next[bdpc_pkg::HIST_W-1];
        cnt_inc      = (cnt_reg < cfg.debounce_threshold) ? cnt_reg + 1'b1 : cnt_reg;
        latch_evt    = stable && (cnt_inc >= cfg.debounce_threshold) && (oldest != latched_reg);

        cnt_next     = stable ? cnt_inc : '0;
        latched_next = latch_evt ? oldest : latched_reg;
        hold_base    = latch_evt ? '0 : hold_reg;
        fired_base   = latch_evt ? 1'b0 : fired_reg;
        short_next   = short_reg;
        long_next    = long_reg;
        if (latch_evt && !oldest && !fired_reg) begin
            short_next = 1'b1;
        end

        hold_next  = hold_base;
        fired_next = fired_base;
        if (latched_next) begin
            if (hold_base != '1) begin
                hold_next = hold_base + 1'b1;
            end
            if (!fired_base &&
                (CMP_W'(hold_next) >= CMP_W'(cfg.long_press_threshold))) begin
                long_next  = 1'b1;
                fired_next = 1'b1;
            end
        end

        // queries never coincide with a tick
        if (!ctl.tick) begin
            hist_next    = hist_reg;
            cnt_next     = cnt_reg;
            latched_next = latched_reg;
            hold_next    = hold_reg;
            fired_next   = fired_reg;
            short_next   = short_reg & ~ctl.clr_short;
            long_next    = long_reg & ~ctl.clr_long;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg    <= '0;
            cnt_reg     <= '0;
            latched_reg <= 1'b0;
            hold_reg    <= '0;
            fired_reg   <= 1'b0;
            short_reg   <= 1'b0;
            long_reg    <= 1'b0;
        end else begin
            hist_reg    <= hist_next;
            cnt_reg     <= cnt_next;
            latched_reg <= latched_next;
            hold_reg    <= hold_next;
            fired_reg   <= fired_next;
            short_reg   <= short_next;
            long_reg    <= long_next;
        end
    end

    assign stat.latched_next = latched_next;
    assign stat.short_flag   = short_reg;
    assign stat.long_flag    = long_reg;

endmodule

### rtl/core/bdpc_merge.sv
// Query decode towards the lanes and merge of lane status into one result beat.
// Depends on bdpc_pkg.
module bdpc_merge #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                                    accept,
    input  bdpc_pkg::in_t                           in_beat,
    input  bdpc_pkg::lane_stat_t [NUM_BUTTONS-1:0]  lane_stat,
    output logic [NUM_BUTTONS-1:0]                  clr_short,
    output logic [NUM_BUTTONS-1:0]                  clr_long,
    output bdpc_pkg::out_t                          result
);

    localparam int SHOW_N = (NUM_BUTTONS < bdpc_pkg::PIN_W) ? NUM_BUTTONS : bdpc_pkg::PIN_W;

    logic [NUM_BUTTONS-1:0]        sel;
    logic [NUM_BUTTONS-1:0]        hit;
    logic [bdpc_pkg::PIN_W-1:0]    shown;
    logic                          q_short, q_long;

    assign q_short = (in_beat.kind == bdpc_pkg::KIND_SHORT);
    assign q_long  = (in_beat.kind == bdpc_pkg::KIND_LONG);

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_dec
        assign sel[b]       = (32'(in_beat.button_index) == b);
        assign hit[b]       = sel[b] && ((q_short && lane_stat[b].short_flag) ||
                                         (q_long  && lane_stat[b].long_flag));
        assign clr_short[b] = accept && sel[b] && q_short;
        assign clr_long[b]  = accept && sel[b] && q_long;
    end

    for (genvar i = 0; i < bdpc_pkg::PIN_W; i++) begin : g_show
        if (i < SHOW_N) begin : g_on
            assign shown[i] = lane_stat[i].latched_next;
        end else begin : g_off
            assign shown[i] = 1'b0;
        end
    end

    assign result.event_taken       = |hit;
    assign result.debounced_pressed = shown;

endmodule

### rtl/core/bdpc_outbuf.sv
// Result register with a skid stage, so input beats keep flowing while one result waits.
// Depends on bdpc_pkg.
module bdpc_outbuf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bdpc_pkg::out_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output bdpc_pkg::out_t  out_data
);

    logic           main_valid_reg, main_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    bdpc_pkg::out_t main_reg, main_next;
    bdpc_pkg::out_t skid_reg, skid_next;
    logic           push, pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

### rtl/core/button_debounce_press_classifier_unit.sv
// Button debounce and press classifier, top level.
// Depends on bdpc_pkg, bdpc_lane, bdpc_merge, bdpc_outbuf.
//
// Input beats (s_valid/s_ready, s_data) are either a tick carrying every pin
// level, or a query that reads and clears one button's short- or long-press
// flag. Every accepted beat yields exactly one result beat on m_valid/m_ready
// with event_taken and the debounced pressed vector after that beat.
// One lane per button updates its state in the cycle the beat is accepted;
// a merge stage builds the result, which is registered.
// An accepted result enters the result register if it is empty or draining,
// else the skid stage. One beat is taken per cycle while s_ready is high.
// A result register plus a skid stage hold up to two results; s_ready falls
// only once both are full while m_ready is low, and rises again as the
// receiver drains them.
// Configuration is written through cfg_valid/cfg_ready (always ready) with
// cfg_index 0 debounce threshold, 1 long-press threshold, 2 pressed level;
// other indices are ignored. Write only while the block is idle.
// Synchronous active-low reset clears all button state and loads the
// default thresholds (2, 100) and pressed level 0; no result is pending.
module button_debounce_press_classifier_unit #(
    parameter int NUM_BUTTONS = 8,
    parameter int HOLD_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bdpc_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bdpc_pkg::out_t                      m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bdpc_pkg::cfg_t                          cfg_reg, cfg_next;
    bdpc_pkg::lane_stat_t [NUM_BUTTONS-1:0]  lane_stat;
    logic [NUM_BUTTONS-1:0]                  clr_short, clr_long;
    bdpc_pkg::out_t                          result;
    logic                                    accept, is_tick;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bdpc_pkg::CFG_DEBOUNCE:
                    cfg_next.debounce_threshold = cfg_data[bdpc_pkg::DBT_W-1:0];
                bdpc_pkg::CFG_LONG:
                    cfg_next.long_press_threshold = cfg_data[bdpc_pkg::LPT_W-1:0];
                bdpc_pkg::CFG_LEVEL:
                    cfg_next.pressed_level = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_threshold   <= bdpc_pkg::DBT_RESET;
            cfg_reg.long_press_threshold <= bdpc_pkg::LPT_RESET;
            cfg_reg.pressed_level        <= bdpc_pkg::LEVEL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept  = s_valid && s_ready;
    assign is_tick = accept && (s_data.kind == bdpc_pkg::KIND_TICK);

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        bdpc_pkg::lane_ctl_t ctl;
        if (b < bdpc_pkg::PIN_W) begin : g_pin
            assign ctl.pressed = (s_data.pin_levels[b] == cfg_reg.pressed_level);
        end else begin : g_nopin
            assign ctl.pressed = 1'b0;   // no pin: always samples released
        end
        assign ctl.tick      = is_tick;
        assign ctl.clr_short = clr_short[b];
        assign ctl.clr_long  = clr_long[b];

        bdpc_lane #(
            .HOLD_BITS (HOLD_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg_reg),
            .ctl     (ctl),
            .stat    (lane_stat[b])
        );
    end

    bdpc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .accept    (accept),
        .in_beat   (s_data),
        .lane_stat (lane_stat),
        .clr_short (clr_short),
        .clr_long  (clr_long),
        .result    (result)
    );

    bdpc_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

### rtl/core/bdpc_checker.sv
// Port-level checks on the button debounce and press classifier top level.
// Depends on bdpc_pkg; bound to button_debounce_press_classifier_unit below.
module bdpc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input bdpc_pkg::out_t m_data
);

    // nothing pending straight out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // input stalls only while a result is waiting
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with no result waiting");

    // an accepted beat into an empty output shows up the next cycle
    a_result_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> m_valid)
        else $error("result missing one cycle after acceptance");

    // second result while the first is stalled fills the skid stage
    a_skid_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_valid && !m_ready |=> !s_ready)
        else $error("skid stage not holding a second result");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### dv/button_debounce_press_classifier_unit_test.sv
// Self-checking testbench for button_debounce_press_classifier_unit.
// Depends on bdpc_pkg and the unit itself. A predictor of the debounce and
// press flags is checked against every result beat.
module button_debounce_press_classifier_unit_test;
    import bdpc_pkg::*;

    localparam int BUTTONS     = 8;
    localparam int HOLD_W      = 16;
    localparam int STALL_LIMIT = 2000;   // cycles with no beat moving anywhere
    localparam int DRAIN_SLACK = 8;
    localparam int RX_OPEN     = 0;
    localparam int RX_HALF     = 1;
    localparam int RX_TIGHT    = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // decodes to nothing

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predicted block state
    logic [DBT_W-1:0]  debounce_q;
    logic [LPT_W-1:0]  long_thr_q;
    logic              level_q;
    logic [2:0]        hist_q [BUTTONS];
    logic [CNT_W-1:0]  stable_q [BUTTONS];
    logic [HOLD_W-1:0] hold_q [BUTTONS];
    logic [BUTTONS-1:0] pressed_q, fired_q, short_q, long_flag_q;

    out_t awaited_results [$];

    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left  = 0;
    bit          gaps_on     = 1'b1;
    int unsigned ticks_sent  = 0;
    int unsigned reads_sent  = 0;
    int unsigned flags_taken = 0;
    int unsigned reg_writes  = 0;
    logic [5:0]  rx_phase    = '0;
    int          rx_mode     = RX_OPEN;

    button_debounce_press_classifier_unit #(
        .NUM_BUTTONS(BUTTONS),
        .HOLD_BITS  (HOLD_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic void advance_tick(logic [PIN_W-1:0] pins);
        logic [2:0] h;
        for (int b = 0; b < BUTTONS; b++) begin
            h = {hist_q[b][1:0], pins[b] == level_q};
            hist_q[b] = h;
            if (h == 3'b000 || h == 3'b111) begin
                if (stable_q[b] < debounce_q)
                    stable_q[b]++;
                if (stable_q[b] >= debounce_q && h[2] != pressed_q[b]) begin
                    pressed_q[b] = h[2];
                    // a release only counts as short if no long press fired
                    if (!h[2] && !fired_q[b])
                        short_q[b] = 1'b1;
                    hold_q[b]  = '0;
                    fired_q[b] = 1'b0;
                end
            end else begin
                stable_q[b] = '0;
            end
            if (pressed_q[b]) begin
                if (hold_q[b] != '1)
                    hold_q[b]++;
                if (!fired_q[b] && hold_q[b] >= long_thr_q) begin
                    long_flag_q[b] = 1'b1;
                    fired_q[b]     = 1'b1;
                end
            end
        end
    endfunction

    function automatic out_t press_outcome(in_t beat);
        out_t r;
        r.event_taken = 1'b0;
        case (kind_t'(beat.kind))
            KIND_TICK: advance_tick(beat.pin_levels);
            KIND_SHORT: begin
                if (short_q[beat.button_index]) begin
                    short_q[beat.button_index] = 1'b0;
                    r.event_taken = 1'b1;
                end
            end
            KIND_LONG: begin
                if (long_flag_q[beat.button_index]) begin
                    long_flag_q[beat.button_index] = 1'b0;
                    r.event_taken = 1'b1;
                end
            end
            default: ;
        endcase
        r.debounced_pressed = pressed_q;
        return r;
    endfunction

    function automatic in_t make_beat(kind_t k, logic [PIN_W-1:0] pins,
                                      logic [IDX_W-1:0] idx);
        in_t b;
        b.kind         = k;
        b.pin_levels   = pins;
        b.button_index = idx;
        return b;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_beat(in_t beat);
        out_t r;
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            // occasional long bursts leave stretches with no idling
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        r = press_outcome(beat);
        awaited_results.push_back(r);
        if (kind_t'(beat.kind) == KIND_TICK)
            ticks_sent++;
        else if (kind_t'(beat.kind) != KIND_NONE)
            reads_sent++;
        if (r.event_taken)
            flags_taken++;
    endtask

    task automatic tick_pins(logic [PIN_W-1:0] pins);
        send_beat(make_beat(KIND_TICK, pins, IDX_W'($urandom)));
    endtask

    task automatic ask_flag(kind_t k, logic [IDX_W-1:0] idx);
        send_beat(make_beat(k, PIN_W'($urandom), idx));
    endtask

    // sender holds off until every awaited result has been taken
    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (awaited_results.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: debounce_q = val[DBT_W-1:0];
            CFG_LONG:     long_thr_q = val[LPT_W-1:0];
            CFG_LEVEL:    level_q    = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // receiver: ready pattern switches mode each time the 6-bit phase counter wraps
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_phase == '0)
            rx_mode <= $urandom_range(RX_OPEN, RX_TIGHT);
        case (rx_mode)
            RX_OPEN: m_ready <= 1'b1;
            RX_HALF: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch("result beat with nothing awaited", 0, 32'(m_data));
            end else begin
                want = awaited_results.pop_front();
                if (m_data.event_taken !== want.event_taken)
                    flag_mismatch("event_taken", 32'(want.event_taken),
                                  32'(m_data.event_taken));
                if (m_data.debounced_pressed !== want.debounced_pressed)
                    flag_mismatch("debounced_pressed", 32'(want.debounced_pressed),
                                  32'(m_data.debounced_pressed));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    task automatic test_defaults_and_queries();
        ask_flag(KIND_SHORT, 3'd0);
        ask_flag(KIND_LONG, 3'd7);
        send_beat(make_beat(KIND_NONE, 8'hFF, 3'd7));
        repeat (4) tick_pins(8'h00);          // level 0 is pressed by default
        repeat (4) tick_pins(8'hFF);          // release, short flags set
        ask_flag(KIND_SHORT, 3'd0);
        ask_flag(KIND_SHORT, 3'd0);           // already cleared
        ask_flag(KIND_SHORT, 3'd7);
        ask_flag(KIND_LONG, 3'd3);
        send_beat(make_beat(KIND_NONE, 8'h00, 3'd0));
        tick_pins(8'h55);                     // bouncing pins never settle
        tick_pins(8'hAA);
        tick_pins(8'h55);
        tick_pins(8'hAA);
    endtask

    task automatic test_zero_thresholds();
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_LONG, 16'd0);
        write_reg(CFG_LEVEL, 16'd1);
        write_reg(CFG_SPARE, 16'hFFFF);
        repeat (3) tick_pins(8'h81);          // long fires once the pressed history is stable
        ask_flag(KIND_LONG, 3'd0);
        ask_flag(KIND_LONG, 3'd7);
        repeat (3) tick_pins(8'h00);
        ask_flag(KIND_SHORT, 3'd0);           // no short after a long
        ask_flag(KIND_LONG, 3'd0);
    endtask

    task automatic test_long_press();
        write_reg(CFG_DEBOUNCE, 16'd255);
        write_reg(CFG_LONG, 16'hFFFF);
        write_reg(CFG_LEVEL, 16'd1);
        repeat (12) tick_pins(8'h01);         // full-scale debounce: nothing latches yet
        write_reg(CFG_DEBOUNCE, 16'd3);
        write_reg(CFG_LONG, 16'd60);
        gaps_on = 1'b0;
        for (int i = 0; i < 72; i++) begin
            tick_pins(8'h01);
            if (i % 16 == 0)
                ask_flag(KIND_LONG, 3'd0);
        end
        ask_flag(KIND_LONG, 3'd0);
        ask_flag(KIND_LONG, 3'd0);
        repeat (8) tick_pins(8'h00);
        ask_flag(KIND_SHORT, 3'd0);           // long already fired, so no short
        gaps_on = 1'b1;
    endtask

    task automatic random_phase(int unsigned n);
        int unsigned counted;
        int unsigned run_len;
        logic [PIN_W-1:0] held;
        counted = 0;
        held = PIN_W'($urandom);
        while (counted < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    // clean press/release run, bounce only on the leading ticks
                    held ^= PIN_W'($urandom);
                    run_len = $urandom_range(1, 45);
                    for (int i = 0; i < run_len; i++) begin
                        if (i < 3 && $urandom_range(0, 1))
                            tick_pins(held ^ PIN_W'($urandom));
                        else
                            tick_pins(held);
                        counted++;
                        if ($urandom_range(0, 7) == 0) begin
                            ask_flag($urandom_range(0, 1) ? KIND_SHORT : KIND_LONG,
                                     IDX_W'($urandom));
                            counted++;
                        end
                    end
                end
                6, 7: begin
                    ask_flag($urandom_range(0, 1) ? KIND_SHORT : KIND_LONG,
                             IDX_W'($urandom));
                    counted++;
                end
                8: begin
                    tick_pins(PIN_W'($urandom));
                    counted++;
                end
                default: begin
                    send_beat(make_beat(KIND_NONE, PIN_W'($urandom), IDX_W'($urandom)));
                    if ($urandom_range(0, 3) == 0)
                        wait_drained();
                end
            endcase
        end
    endtask

    task automatic test_random_presses();
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 5)));
            write_reg(CFG_LONG, 16'($urandom_range(0, 40)));
            write_reg(CFG_LEVEL, 16'($urandom_range(0, 1)));
            random_phase(120);
        end
    endtask

    initial begin
        debounce_q  = DBT_RESET;
        long_thr_q  = LPT_RESET;
        level_q     = LEVEL_RESET;
        pressed_q   = '0;
        fired_q     = '0;
        short_q     = '0;
        long_flag_q = '0;
        for (int b = 0; b < BUTTONS; b++) begin
            hist_q[b]   = '0;
            stable_q[b] = '0;
            hold_q[b]   = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_defaults_and_queries();
        test_zero_thresholds();
        test_long_press();
        test_random_presses();

        wait_drained();
        repeat (DRAIN_SLACK) @(posedge aclk);
        $display("covered %0d ticks and %0d flag reads (%0d flags taken)",
                 ticks_sent, reads_sent, flags_taken);
        $display("across %0d register writes, thresholds from zero to full scale",
                 reg_writes);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     mismatches, awaited_results.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
